/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and the microprogram of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  NEWLINE_CHAR = 8'd10;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_PLACE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam int UPC_W = 4;

  localparam logic [UPC_W-1:0] STEP_DONE   = 4'd0;
  localparam logic [UPC_W-1:0] STEP_FETCH  = 4'd1;
  localparam logic [UPC_W-1:0] STEP_APPEND = 4'd2;
  localparam logic [UPC_W-1:0] STEP_APP_WR = 4'd3;
  localparam logic [UPC_W-1:0] STEP_ADV    = 4'd4;
  localparam logic [UPC_W-1:0] STEP_NL     = 4'd5;
  localparam logic [UPC_W-1:0] STEP_SCR_RD = 4'd6;
  localparam logic [UPC_W-1:0] STEP_SCR_WR = 4'd7;
  localparam logic [UPC_W-1:0] STEP_TAIL   = 4'd8;
  localparam logic [UPC_W-1:0] STEP_CLR    = 4'd9;
  localparam logic [UPC_W-1:0] STEP_FILL   = 4'd10;
  localparam logic [UPC_W-1:0] STEP_PLACE  = 4'd11;

  typedef enum logic [3:0] {
    A_NONE,
    A_EMIT,
    A_LATCH,
    A_WR_CURSOR,
    A_COL_INC,
    A_NEWLINE,
    A_RD_SRC,
    A_WR_COPY,
    A_SET_TAIL,
    A_SET_ZERO,
    A_WR_BLANK,
    A_WR_INDEX
  } act_t;

  typedef enum logic [3:0] {
    J_NEXT,
    J_ALWAYS,
    J_DISPATCH,
    J_NEWLINE,
    J_LASTCOL,
    J_NOT_LASTROW,
    J_MORE,
    J_WAIT_OUT,
    J_WAIT_LAST
  } jmp_t;

  typedef struct packed {
    act_t             act;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    act_t act;
    logic accept;
    logic quiet;
  } ctrl_t;

  typedef struct packed {
    logic newline;
    logic last_col;
    logic last_row;
    logic cnt_last;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      STEP_DONE:   w = '{A_EMIT,      J_WAIT_OUT,    STEP_FETCH};
      STEP_FETCH:  w = '{A_LATCH,     J_DISPATCH,    STEP_FETCH};
      STEP_APPEND: w = '{A_NONE,      J_NEWLINE,     STEP_NL};
      STEP_APP_WR: w = '{A_WR_CURSOR, J_LASTCOL,     STEP_NL};
      STEP_ADV:    w = '{A_COL_INC,   J_ALWAYS,      STEP_DONE};
      STEP_NL:     w = '{A_NEWLINE,   J_NOT_LASTROW, STEP_DONE};
      STEP_SCR_RD: w = '{A_RD_SRC,    J_NEXT,        STEP_SCR_WR};
      STEP_SCR_WR: w = '{A_WR_COPY,   J_MORE,        STEP_SCR_RD};
      STEP_TAIL:   w = '{A_SET_TAIL,  J_ALWAYS,      STEP_FILL};
      STEP_CLR:    w = '{A_SET_ZERO,  J_NEXT,        STEP_FILL};
      STEP_FILL:   w = '{A_WR_BLANK,  J_WAIT_LAST,   STEP_DONE};
      STEP_PLACE:  w = '{A_WR_INDEX,  J_ALWAYS,      STEP_DONE};
      default:     w = '{A_NONE,      J_ALWAYS,      STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* design/tcw_sequencer.sv */
// ----------------------------------------------------------------------------
// tcw_sequencer
// Microprogram counter with conditional jumps and kind dispatch.
// ----------------------------------------------------------------------------
module tcw_sequencer
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  input  status_t    status,
  output ctrl_t      ctrl,
  output logic       in_stall
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             init_r, init_nxt;
  uword_t           uw;
  logic             accept;

  assign uw       = ucode_rom(upc_r);
  assign in_stall = init_r || (upc_r != STEP_FETCH);
  assign accept   = in_valid && !in_stall;

  assign ctrl.act    = uw.act;
  assign ctrl.accept = accept;
  assign ctrl.quiet  = init_r;

  always_comb begin
    upc_nxt  = upc_r + UPC_W'(1);
    init_nxt = init_r;
    case (uw.jmp)
      J_NEXT:        upc_nxt = upc_r + UPC_W'(1);
      J_ALWAYS:      upc_nxt = uw.target;
      J_DISPATCH: begin
        if (!accept) begin
          upc_nxt = upc_r;
        end else begin
          case (in_kind)
            KIND_APPEND: upc_nxt = STEP_APPEND;
            KIND_PLACE:  upc_nxt = STEP_PLACE;
            KIND_CLEAR:  upc_nxt = STEP_CLR;
            default:     upc_nxt = STEP_DONE;
          endcase
        end
      end
      J_NEWLINE:     upc_nxt = status.newline ? uw.target : upc_r + UPC_W'(1);
      J_LASTCOL:     upc_nxt = status.last_col ? uw.target : upc_r + UPC_W'(1);
      J_NOT_LASTROW: upc_nxt = !status.last_row ? uw.target : upc_r + UPC_W'(1);
      J_MORE:        upc_nxt = !status.cnt_last ? uw.target : upc_r + UPC_W'(1);
      J_WAIT_OUT:    upc_nxt = status.out_busy ? upc_r : uw.target;
      J_WAIT_LAST:   upc_nxt = status.cnt_last ? uw.target : upc_r;
      default:       upc_nxt = STEP_FETCH;
    endcase
    if (uw.act == A_EMIT && !status.out_busy) begin
      init_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= STEP_CLR;
      init_r <= 1'b1;
    end else begin
      upc_r  <= upc_nxt;
      init_r <= init_nxt;
    end
  end

  property p_no_accept_during_init;
    @(posedge clk) disable iff (!rst_n) init_r |-> in_stall;
  endproperty
  a_no_accept_during_init: assert property (p_no_accept_during_init)
    else $error("word accepted during the clearing pass");

endmodule

/* design/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, address counter, cell memory and result register.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_t       ctrl,
  output status_t     status,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_color,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_position,
  output logic        out_scrolled
);

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int EXT_W  = ADDR_W + 11;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;

  logic [7:0]        char_r, char_nxt;
  logic [7:0]        color_r, color_nxt;
  logic [10:0]       idx_r, idx_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              scroll_r, scroll_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [10:0]       out_pos_r, out_pos_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic [EXT_W-1:0]  idx_ext;
  logic [EXT_W-1:0]  pos_ext;
  logic              idx_ok;

  assign idx_ext = {{ADDR_W{1'b0}}, idx_r};
  assign pos_ext = {11'd0, pos_r};
  assign idx_ok  = idx_ext < EXT_W'(CELLS);

  assign status.newline  = (char_r == NEWLINE_CHAR);
  assign status.last_col = (col_r == COL_W'(COLS - 1));
  assign status.last_row = (row_r == ROW_W'(ROWS - 1));
  assign status.cnt_last = (cnt_r == ADDR_W'(CELLS - 1));
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_scrolled        = out_scr_r;

  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = BLANK_CELL;
    case (ctrl.act)
      A_WR_CURSOR: begin
        we = 1'b1;
        wa = pos_r;
        wd = {color_r, char_r};
      end
      A_WR_COPY: begin
        we = 1'b1;
        wa = cnt_r - ADDR_W'(COLS);
        wd = rd_data_r;
      end
      A_WR_BLANK: begin
        we = 1'b1;
        wa = cnt_r;
        wd = BLANK_CELL;
      end
      A_WR_INDEX: begin
        we = idx_ok;
        wa = idx_ext[ADDR_W-1:0];
        wd = {color_r, char_r};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[cnt_r];
  end

  always_comb begin
    char_nxt      = char_r;
    color_nxt     = color_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    scroll_nxt    = scroll_r;
    cnt_nxt       = cnt_r;
    out_pos_nxt   = out_pos_r;
    out_scr_nxt   = out_scr_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (ctrl.act)
      A_LATCH: begin
        if (ctrl.accept) begin
          char_nxt   = in_char_code;
          color_nxt  = in_color;
          idx_nxt    = in_cell_index;
          scroll_nxt = 1'b0;
        end
      end
      A_COL_INC: begin
        col_nxt = col_r + COL_W'(1);
        pos_nxt = pos_r + ADDR_W'(1);
      end
      A_NEWLINE: begin
        col_nxt = '0;
        if (status.last_row) begin
          pos_nxt    = ADDR_W'((ROWS - 1) * COLS);
          scroll_nxt = 1'b1;
          cnt_nxt    = ADDR_W'(COLS);
        end else begin
          row_nxt = row_r + ROW_W'(1);
          pos_nxt = pos_r + ADDR_W'(COLS) - ADDR_W'(col_r);
        end
      end
      A_WR_COPY:  cnt_nxt = cnt_r + ADDR_W'(1);
      A_SET_TAIL: cnt_nxt = ADDR_W'(CELLS - COLS);
      A_SET_ZERO: cnt_nxt = '0;
      A_WR_BLANK: cnt_nxt = cnt_r + ADDR_W'(1);
      A_EMIT: begin
        if (!status.out_busy && !ctrl.quiet) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_ext[10:0];
          out_scr_nxt   = scroll_r;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      scroll_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      scroll_r    <= scroll_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r    <= char_nxt;
    color_r   <= color_nxt;
    idx_r     <= idx_nxt;
    out_pos_r <= out_pos_nxt;
    out_scr_r <= out_scr_nxt;
  end

  property p_pos_matches;
    @(posedge clk) disable iff (!rst_n)
      pos_r == ADDR_W'(row_r * COLS + col_r);
  endproperty
  a_pos_matches: assert property (p_pos_matches)
    else $error("linear cursor position disagrees with row and column");

  property p_cursor_range;
    @(posedge clk) disable iff (!rst_n)
      (row_r <= ROW_W'(ROWS - 1)) && (col_r <= COL_W'(COLS - 1));
  endproperty
  a_cursor_range: assert property (p_cursor_range)
    else $error("cursor left the screen");

  property p_scroll_last_row;
    @(posedge clk) disable iff (!rst_n) scroll_r |-> status.last_row;
  endproperty
  a_scroll_last_row: assert property (p_scroll_last_row)
    else $error("scroll flagged while cursor is not on the last row");

endmodule

/* design/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console cell store with cursor, scroll, place and clear operations.
// ----------------------------------------------------------------------------
// Each word takes its own microprogram path (append, newline, place, clear, and a
// scrolling append or newline). The result is registered by the emit step (STEP_DONE)
// at the end of the path, which waits while an earlier result is stalled; the next word
// is accepted while that result waits. Copy and fill walk the memory one cell at a
// time. After reset a clearing pass blanks the store before the first word is
// accepted; the cursor resets to row 0, column 0.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_color,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_position,
  output logic        out_scrolled
);

  ctrl_t   ctrl;
  status_t status;

  tcw_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .status              (status),
    .in_char_code        (in_char_code),
    .in_color            (in_color),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_scrolled        (out_scrolled)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of text_console_writer_unit. A driver sends append, place, clear
// and unused-kind words in random bursts, and a cursor predictor works out the
// cursor position and scroll flag that each accepted word must return. A
// monitor stalls the result channel on its own pattern and compares every
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int ROWS  = ROWS_DEF;
  localparam int COLS  = COLS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam int WORD_TARGET = 2000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
    logic        settle;
  } console_word_t;

  typedef struct packed {
    logic [10:0] position;
    logic        scrolled;
  } cursor_report_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HEAVY,
    FLOW_TOGGLE
  } flow_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_color = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_cursor_position;
  logic        out_scrolled;

  console_word_t  words_to_send[$];
  cursor_report_t cursor_reports_q[$];
  console_word_t  word_out = '0;
  logic           word_held = 1'b0;
  logic           settle_pending = 1'b0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             cursor_row = 0;
  int             cursor_col = 0;
  int             fault_count = 0;
  int             results_seen = 0;
  int             mode_left = 0;
  int             hold_left = 0;
  logic           hold_done = 1'b0;
  logic           stall_now;
  flow_mode_t     flow_mode = FLOW_FREE;
  cursor_report_t want;

  text_console_writer_unit #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .in_color            (in_color),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_scrolled        (out_scrolled)
  );

  always #6 clk = ~clk;

  function automatic cursor_report_t advance_cursor(input console_word_t w);
    cursor_report_t r;
    r.scrolled = 1'b0;
    if (w.kind == KIND_APPEND) begin
      if (w.char_code == NEWLINE_CHAR || cursor_col >= COLS - 1) begin
        cursor_col = 0;
        if (cursor_row >= ROWS - 1) begin
          cursor_row = ROWS - 1;
          r.scrolled = 1'b1;
        end else begin
          cursor_row++;
        end
      end else begin
        cursor_col++;
      end
    end
    r.position = 11'(cursor_row * COLS + cursor_col);
    return r;
  endfunction

  function automatic void add_word(input logic [1:0] kind, input logic [7:0] ch,
                                   input logic [7:0] color, input logic [10:0] idx);
    words_to_send.push_back('{kind, ch, color, idx, settle_pending});
    settle_pending = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      word_held = 1'b0;
    end else begin
      if (word_held && !in_stall) begin
        cursor_reports_q.push_back(advance_cursor(word_out));
        word_held = 1'b0;
      end
      if (!word_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (words_to_send.size() != 0 &&
                     !(words_to_send[0].settle && cursor_reports_q.size() != 0)) begin
          word_out = words_to_send.pop_front();
          word_held = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3:       gap_left = $urandom_range(20, 80);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
      in_valid      <= word_held;
      in_kind       <= word_out.kind;
      in_char_code  <= word_out.char_code;
      in_color      <= word_out.color;
      in_cell_index <= word_out.cell_index;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cursor_reports_q.size() == 0) begin
          $error("Unexpected result: cursor_position %0d, scrolled %0d",
                 out_cursor_position, out_scrolled);
          fault_count++;
        end else begin
          want = cursor_reports_q.pop_front();
          if (out_cursor_position !== want.position) begin
            $error("cursor_position: expected %0d, actual %0d",
                   want.position, out_cursor_position);
            fault_count++;
          end
          if (out_scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, actual %0d", want.scrolled, out_scrolled);
            fault_count++;
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        case (flow_mode)
          FLOW_FREE:  stall_now = 1'b0;
          FLOW_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
          FLOW_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
          default:    stall_now = ~out_stall;
        endcase
      end
      out_stall <= stall_now;
    end
  end

  initial begin
    int k;
    int line_len;
    int next_settle;
    logic [7:0] ink;

    add_word(KIND_APPEND, 8'h41, 8'h0F, 11'd0);
    add_word(KIND_APPEND, 8'h00, 8'h00, 11'h7FF);
    add_word(KIND_APPEND, 8'hFF, 8'hFF, 11'd0);
    add_word(KIND_APPEND, NEWLINE_CHAR, 8'h0E, 11'd0);
    add_word(KIND_PLACE, 8'h42, 8'h28, 11'd0);
    add_word(KIND_PLACE, 8'hFF, 8'hFF, 11'(CELLS - 1));
    add_word(KIND_PLACE, 8'h78, 8'h07, 11'(CELLS));
    add_word(KIND_PLACE, 8'h00, 8'h00, 11'h7FF);
    add_word(KIND_PLACE, NEWLINE_CHAR, 8'h07, 11'd500);
    add_word(KIND_PLACE, 8'h55, 8'hAA, 11'h555);
    add_word(KIND_PLACE, 8'hAA, 8'h55, 11'h2AA);
    add_word(2'd3, 8'hFF, 8'hFF, 11'h7FF);
    add_word(2'd3, 8'h00, 8'h00, 11'd0);
    add_word(KIND_CLEAR, 8'h00, 8'h00, 11'd0);
    add_word(KIND_APPEND, 8'h43, 8'h0F, 11'd0);
    add_word(KIND_APPEND, NEWLINE_CHAR, 8'h28, 11'd0);
    add_word(2'd3, NEWLINE_CHAR, 8'h0E, 11'd3);

    // Mostly lines of text ending in a newline, so that the cursor reaches
    // the bottom row and the screen scrolls; long lines wrap at the last column.
    settle_pending = 1'b1;
    next_settle = 600;
    while (words_to_send.size() < WORD_TARGET) begin
      if (words_to_send.size() >= next_settle) begin
        settle_pending = 1'b1;
        next_settle += 600;
      end
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(COLS - 6, COLS + 10)
                                                 : $urandom_range(0, 20);
          ink = 8'($urandom);
          for (k = 0; k < line_len; k++)
            add_word(KIND_APPEND, 8'($urandom_range(32, 126)), ink, 11'($urandom));
          if ($urandom_range(0, 9) < 7)
            add_word(KIND_APPEND, NEWLINE_CHAR, ink, 11'($urandom));
        end
        [60:79]: begin
          line_len = $urandom_range(1, 5);
          for (k = 0; k < line_len; k++)
            add_word(KIND_PLACE, 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 4) == 0) ? 11'($urandom_range(CELLS, 2047))
                                                 : 11'($urandom_range(0, CELLS - 1)));
        end
        [80:81]: add_word(KIND_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
        [82:84]: add_word(2'd3, 8'($urandom), 8'($urandom), 11'($urandom));
        default: begin
          line_len = $urandom_range(1, 4);
          for (k = 0; k < line_len; k++)
            add_word(($urandom_range(0, 9) == 0) ? 2'd3
                     : 2'($urandom_range(0, 1)),
                     8'($urandom), 8'($urandom), 11'($urandom));
        end
      endcase
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (words_to_send.size() != 0 || word_held) @(posedge clk);
    while (cursor_reports_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #360_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
